// ===== rtl/layer_priority_pixel_mixer_top_defines.svh =====
// Assertion macros shared by the pixel mixer RTL.
`ifndef LAYER_PRIORITY_PIXEL_MIXER_TOP_DEFINES_SVH
`define LAYER_PRIORITY_PIXEL_MIXER_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define LPPM_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that holds in every cycle, reset included.
`define LPPM_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lppm_pkg.sv =====
// Types, codes and helpers of the layer priority pixel mixer.
package lppm_pkg;

  localparam int InDataW   = 128;
  localparam int OutDataW  = 16;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;

  localparam logic [7:0] KeyColourReset = 8'd227;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexW-1:0] CFG_PRIORITY_ORDER  = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_BLEND_SELECT    = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_STENCIL_ENABLE  = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_KEY_COLOUR      = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_FALLBACK_COLOUR = 3'd4;

  typedef enum logic [2:0] {
    PRI_SLU       = 3'd0,
    PRI_LSU       = 3'd1,
    PRI_SUL       = 3'd2,
    PRI_LUS       = 3'd3,
    PRI_USL       = 3'd4,
    PRI_ULS       = 3'd5,
    PRI_BLEND_SAT = 3'd6,
    PRI_BLEND_M5  = 3'd7
  } prio_t;

  typedef enum logic [1:0] {
    MIX_ULA     = 2'd0,
    MIX_NONE    = 2'd1,
    MIX_ULA_TM  = 2'd2,
    MIX_TILEMAP = 2'd3
  } mix_sel_t;

  // Stage 1: transparency decisions and the merged ULA/tilemap layer.
  typedef struct packed {
    logic        ula_t;
    logic        tm_t;
    logic        l2_t;
    logic        l2_pri;
    logic        spr_t;
    logic        fin_t;
    logic        ula_show;
    logic        umix_t;
    logic        tm_below;
    logic [15:0] ula_c16;
    logic [8:0]  ula_c9;
    logic [15:0] tm_c16;
    logic [8:0]  tm_c9;
    logic [15:0] fin_c16;
    logic [8:0]  fin_c9;
    logic [15:0] spr_c;
    logic [15:0] l2_c16;
    logic [8:0]  l2_c9;
  } s1_t;

  // Stage 2: the chosen direct colour, or the channel sums of a blend.
  typedef struct packed {
    logic        use_blend;
    logic        mix_t;
    logic [15:0] direct;
    logic [3:0]  sum_r;
    logic [3:0]  sum_g;
    logic [3:0]  sum_b;
  } s2_t;

  // Clamps a blend sum to three bits; M5 with opaque mix subtracts 5.
  function automatic logic [2:0] blend_adjust(logic [3:0] s, logic sat_mode, logic mix_t);
    logic [3:0] v;
    v = s;
    if (sat_mode) begin
      if (v[3]) v = 4'd7;
    end else if (!mix_t) begin
      if (v <= 4'd4) v = 4'd0;
      else if (v[3:2] == 2'b11) v = 4'd7;
      else v = v - 4'd5;
    end
    return (v > 4'd7) ? 3'd7 : v[2:0];
  endfunction

endpackage

// ===== rtl/layer_priority_pixel_mixer_top.sv =====
// Top level of the layer priority pixel mixer: a three-stage pixel pipeline.
//
//  Channel | Direction | Beat contents
//  --------+-----------+-------------------------------------------------
//  s_*     | in        | one pixel: flags and colours of all four layers
//  m_*     | out       | one 16-bit output colour per input pixel
//  wr_*    | in        | register writes, one per cycle, no read-back
//
// A pixel passes through the three register stages from input beat to output
// beat, and one pixel can enter in every cycle while the output is not stalled.
// Reset is synchronous; it clears the stage valid bits and loads the configuration registers with their reset values.
// A stall at the output holds the stages back one by one; a stage takes new
// data whenever it is empty or the stage after it moves on.
`include "layer_priority_pixel_mixer_top_defines.svh"

module layer_priority_pixel_mixer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // ula_flags[2:0], ula_colour[35:3], tile_flags[39:36], tile_colour[72:40],
  // sprite_present[73], sprite_colour[89:74], layer2_present[90],
  // layer2_over[91], layer2_colour[124:92], zero fill [127:125]
  input  logic [lppm_pkg::InDataW-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pixel_colour[15:0]
  output logic [lppm_pkg::OutDataW-1:0]  m_tdata,
  input  logic                           wr_en,
  input  logic [lppm_pkg::CfgIndexW-1:0] wr_index,
  input  logic [lppm_pkg::CfgDataW-1:0]  wr_data
);
  import lppm_pkg::*;

  // Configuration registers.
  prio_t       priority_order;
  mix_sel_t    blend_select;
  logic        stencil_enable;
  logic [7:0]  key_colour;
  logic [15:0] fallback_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_order  <= PRI_SLU;
      blend_select    <= MIX_ULA;
      stencil_enable  <= 1'b0;
      key_colour      <= KeyColourReset;
      fallback_colour <= 16'd0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_PRIORITY_ORDER:  priority_order  <= prio_t'(wr_data[2:0]);
        CFG_BLEND_SELECT:    blend_select    <= mix_sel_t'(wr_data[1:0]);
        CFG_STENCIL_ENABLE:  stencil_enable  <= wr_data[0];
        CFG_KEY_COLOUR:      key_colour      <= wr_data[7:0];
        CFG_FALLBACK_COLOUR: fallback_colour <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  logic v1, v2;
  logic r2, r3;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  logic [15:0] out_next;

  assign r3       = !m_tvalid || m_tready;
  assign r2       = !v2 || r3;
  assign s_tready = !v1 || r2;

  // Input field unpacking.
  logic [2:0]  ula_flags;
  logic [32:0] ula_colour;
  logic [3:0]  tile_flags;
  logic [32:0] tile_colour;
  logic        sprite_present;
  logic [15:0] sprite_colour;
  logic        layer2_present;
  logic        layer2_over;
  logic [32:0] layer2_colour;

  assign ula_flags      = s_tdata[2:0];
  assign ula_colour     = s_tdata[35:3];
  assign tile_flags     = s_tdata[39:36];
  assign tile_colour    = s_tdata[72:40];
  assign sprite_present = s_tdata[73];
  assign sprite_colour  = s_tdata[89:74];
  assign layer2_present = s_tdata[90];
  assign layer2_over    = s_tdata[91];
  assign layer2_colour  = s_tdata[124:92];

  // Stage 1: transparency and the ULA/tilemap merge.
  always_comb begin
    logic ula_t, tm_t, l2_t, stencil_case, fin_t, tm_wins;
    logic [15:0] ula_c16, tm_c16;
    logic [8:0]  ula_c9, tm_c9;
    ula_t = !ula_flags[0] || ula_flags[2] || (ula_colour[7:0] == key_colour);
    tm_t  = !tile_flags[0] || !tile_flags[1] ||
            (tile_flags[3] && (tile_colour[7:0] == key_colour));
    l2_t  = !layer2_present || (layer2_colour[7:0] == key_colour);
    stencil_case = stencil_enable && ula_flags[0] && tile_flags[0];
    tm_wins = 1'b0;

    // Outside the stencil merge a transparent layer reads as black.
    ula_c16 = (!stencil_case && ula_t) ? 16'd0 : ula_colour[32:17];
    ula_c9  = (!stencil_case && ula_t) ? 9'd0  : ula_colour[16:8];
    tm_c16  = (!stencil_case && tm_t)  ? 16'd0 : tile_colour[32:17];
    tm_c9   = (!stencil_case && tm_t)  ? 9'd0  : tile_colour[16:8];

    s1_next.ula_t    = ula_t;
    s1_next.tm_t     = tm_t;
    s1_next.l2_t     = l2_t;
    s1_next.l2_pri   = layer2_over && !l2_t;
    s1_next.spr_t    = !sprite_present;
    s1_next.umix_t   = ula_flags[2] || (ula_colour[7:0] == key_colour);
    s1_next.tm_below = tile_flags[2];
    s1_next.ula_c16  = ula_c16;
    s1_next.ula_c9   = ula_c9;
    s1_next.tm_c16   = tm_c16;
    s1_next.tm_c9    = tm_c9;
    s1_next.spr_c    = sprite_colour;
    s1_next.l2_c16   = layer2_colour[32:17];
    s1_next.l2_c9    = layer2_colour[16:8];

    if (stencil_case) begin
      fin_t = ula_t || tm_t;
      s1_next.fin_c16 = fin_t ? 16'd0 : (ula_colour[32:17] & tile_colour[32:17]);
      s1_next.fin_c9  = fin_t ? 9'd0  : (ula_colour[16:8] & tile_colour[16:8]);
    end else begin
      fin_t   = ula_t && tm_t;
      tm_wins = !tm_t && (!tile_flags[2] || ula_t);
      s1_next.fin_c16 = tm_wins ? tm_c16 : ula_c16;
      s1_next.fin_c9  = tm_wins ? tm_c9  : ula_c9;
    end
    s1_next.fin_t = fin_t;
    // A border pixel with no tilemap over it gives way to a sprite.
    s1_next.ula_show = !fin_t && !(ula_flags[1] && tm_t && sprite_present);
  end

  // Stage 2: priority order, or blend source selection and channel sums.
  always_comb begin
    logic [8:0]  mix_c9;
    logic        mix_t, top_t, bot_t, l2_vis;
    logic [15:0] top_c, bot_c;
    mix_c9 = 9'd0;
    mix_t  = 1'b1;
    top_t  = 1'b1;
    bot_t  = 1'b1;
    top_c  = s1.tm_c16;
    bot_c  = s1.tm_c16;
    l2_vis = !s1.l2_t;

    case (blend_select)
      MIX_ULA: begin
        mix_c9 = s1.umix_t ? 9'd0 : s1.ula_c9;
        mix_t  = s1.umix_t;
        top_t  = s1.tm_t || s1.tm_below;
        bot_t  = s1.tm_t || !s1.tm_below;
      end
      MIX_ULA_TM: begin
        mix_c9 = s1.fin_c9;
        mix_t  = s1.fin_t;
      end
      MIX_TILEMAP: begin
        mix_c9 = s1.tm_c9;
        mix_t  = s1.tm_t;
        top_t  = s1.ula_t || !s1.tm_below;
        top_c  = s1.ula_c16;
        bot_t  = s1.ula_t || s1.tm_below;
        bot_c  = s1.ula_c16;
      end
      default: begin
        if (s1.tm_below) begin
          top_t = s1.ula_t;
          top_c = s1.ula_c16;
        end else begin
          bot_t = s1.ula_t;
          bot_c = s1.ula_c16;
        end
        if (s1.tm_below) bot_t = s1.tm_t;
        else top_t = s1.tm_t;
      end
    endcase

    s2_next.mix_t     = mix_t;
    s2_next.sum_r     = {1'b0, s1.l2_c9[8:6]} + {1'b0, mix_c9[8:6]};
    s2_next.sum_g     = {1'b0, s1.l2_c9[5:3]} + {1'b0, mix_c9[5:3]};
    s2_next.sum_b     = {1'b0, s1.l2_c9[2:0]} + {1'b0, mix_c9[2:0]};
    s2_next.use_blend = 1'b0;
    s2_next.direct    = fallback_colour;

    case (priority_order)
      PRI_SLU: begin
        if (s1.l2_pri) s2_next.direct = s1.l2_c16;
        else if (!s1.spr_t) s2_next.direct = s1.spr_c;
        else if (l2_vis) s2_next.direct = s1.l2_c16;
        else if (!s1.fin_t) s2_next.direct = s1.fin_c16;
      end
      PRI_LSU: begin
        if (l2_vis) s2_next.direct = s1.l2_c16;
        else if (!s1.spr_t) s2_next.direct = s1.spr_c;
        else if (!s1.fin_t) s2_next.direct = s1.fin_c16;
      end
      PRI_SUL: begin
        if (s1.l2_pri) s2_next.direct = s1.l2_c16;
        else if (!s1.spr_t) s2_next.direct = s1.spr_c;
        else if (!s1.fin_t) s2_next.direct = s1.fin_c16;
        else if (l2_vis) s2_next.direct = s1.l2_c16;
      end
      PRI_LUS: begin
        if (l2_vis) s2_next.direct = s1.l2_c16;
        else if (s1.ula_show) s2_next.direct = s1.fin_c16;
        else if (!s1.spr_t) s2_next.direct = s1.spr_c;
      end
      PRI_USL: begin
        if (s1.l2_pri) s2_next.direct = s1.l2_c16;
        else if (s1.ula_show) s2_next.direct = s1.fin_c16;
        else if (!s1.spr_t) s2_next.direct = s1.spr_c;
        else if (l2_vis) s2_next.direct = s1.l2_c16;
      end
      PRI_ULS: begin
        if (s1.l2_pri) s2_next.direct = s1.l2_c16;
        else if (s1.ula_show) s2_next.direct = s1.fin_c16;
        else if (l2_vis) s2_next.direct = s1.l2_c16;
        else if (!s1.spr_t) s2_next.direct = s1.spr_c;
      end
      default: begin
        if (s1.l2_pri) s2_next.use_blend = 1'b1;
        else if (!top_t) s2_next.direct = top_c;
        else if (!s1.spr_t) s2_next.direct = s1.spr_c;
        else if (!bot_t) s2_next.direct = bot_c;
        else if (l2_vis) s2_next.use_blend = 1'b1;
      end
    endcase
  end

  // Stage 3: clamp the blended channels and form the output colour.
  always_comb begin
    logic sat_mode;
    logic [2:0] r, g, b;
    sat_mode = (priority_order == PRI_BLEND_SAT);
    r = blend_adjust(s2.sum_r, sat_mode, s2.mix_t);
    g = blend_adjust(s2.sum_g, sat_mode, s2.mix_t);
    b = blend_adjust(s2.sum_b, sat_mode, s2.mix_t);
    out_next = s2.use_blend ? {r, 1'b0, g, 1'b0, b, 5'd0} : s2.direct;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) s1 <= s1_next;
    if (v1 && r2) s2 <= s2_next;
    if (v2 && r3) m_tdata <= out_next;
  end

  `LPPM_ASSERT_RST(a_in_fills_s1, clk, rst, (s_tvalid && s_tready) |=> v1, "accepted beat lost before stage 1")
  `LPPM_ASSERT_RST(a_s2_reaches_out, clk, rst, (v2 && r3) |=> m_tvalid, "stage 2 beat did not reach the output")
  `LPPM_ASSERT(a_stall_full, clk, !s_tready |-> (v1 && v2 && m_tvalid && !m_tready), "input stalled while the pipeline has room")

endmodule

// ===== dv/layer_priority_pixel_mixer_top_tb.sv =====
// Self-checking stream testbench for the layer priority pixel mixer top level.
`timescale 1ns / 1ps

module layer_priority_pixel_mixer_top_tb;
  import lppm_pkg::*;

  localparam int StallLimit = 1000;
  localparam int NumPhases  = 32;
  localparam int PhaseItems = 29;

  typedef struct packed {
    logic [15:0] c16;
    logic [8:0]  c9;
    logic [7:0]  c8;
  } colour_t;

  typedef struct {
    logic [2:0]  ula_flags;
    logic [32:0] ula_colour;
    logic [3:0]  tile_flags;
    logic [32:0] tile_colour;
    logic        sprite_present;
    logic [15:0] sprite_colour;
    logic        layer2_present;
    logic        layer2_over;
    logic [32:0] layer2_colour;
  } pixel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDataW-1:0]  m_tdata;
  logic                 wr_en = 1'b0;
  logic [CfgIndexW-1:0] wr_index = CFG_PRIORITY_ORDER;
  logic [CfgDataW-1:0]  wr_data = '0;

  // Shadow copies of the mixer registers.
  prio_t       prio_cfg = PRI_SLU;
  mix_sel_t    mix_cfg = MIX_ULA;
  logic        stencil_cfg = 1'b0;
  logic [7:0]  key_cfg = KeyColourReset;
  logic [15:0] fallback_cfg = '0;

  pixel_t      pixels_pending[$];
  logic [15:0] colours_expected[$];
  pixel_t      drv_pixel;
  bit          in_flight = 1'b0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          stall_cnt = 0;
  bit          failed = 1'b0;

  layer_priority_pixel_mixer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [2:0] clamp_channel(logic [3:0] s, logic mix_t);
    logic [3:0] v;
    v = s;
    if (prio_cfg == PRI_BLEND_SAT) begin
      v = s[3] ? 4'd7 : s;
    end else if (!mix_t) begin
      if (s < 4'd5) v = 4'd0;
      else if (s >= 4'd12) v = 4'd7;
      else v = s - 4'd5;
    end
    return (v > 4'd7) ? 3'd7 : v[2:0];
  endfunction

  // Adds the layer 2 and mix rgb9 channels and packs them into rgb16.
  function automatic logic [15:0] blend_colour(logic [8:0] l2, logic [8:0] mx, logic mix_t);
    logic [3:0] r, g, b;
    r = {1'b0, l2[8:6]} + {1'b0, mx[8:6]};
    g = {1'b0, l2[5:3]} + {1'b0, mx[5:3]};
    b = {1'b0, l2[2:0]} + {1'b0, mx[2:0]};
    return {clamp_channel(r, mix_t), 1'b0, clamp_channel(g, mix_t), 1'b0,
            clamp_channel(b, mix_t), 5'b0};
  endfunction

  function automatic logic [15:0] mix_pixel(pixel_t p);
    colour_t ula_raw, tm_raw, l2, ula_c, tm_c, fin_c, mix, top_c, bot_c;
    logic ula_en, ula_rim, ula_clip, tm_en, tm_pix, tm_below, tm_text;
    logic spr_t, ula_t, tm_t, l2_t, l2_pri, fin_t, ula_show, umix_t;
    logic mix_t, top_t, bot_t;
    logic [15:0] res;
    ula_raw    = colour_t'(p.ula_colour);
    tm_raw     = colour_t'(p.tile_colour);
    l2         = colour_t'(p.layer2_colour);
    ula_en     = p.ula_flags[0];
    ula_rim    = p.ula_flags[1];
    ula_clip   = p.ula_flags[2];
    tm_en      = p.tile_flags[0];
    tm_pix     = p.tile_flags[1];
    tm_below   = p.tile_flags[2];
    tm_text    = p.tile_flags[3];
    spr_t      = !p.sprite_present;
    ula_t  = !ula_en || ula_clip || ula_raw.c8 == key_cfg;
    tm_t   = !tm_en || !tm_pix || (tm_text && tm_raw.c8 == key_cfg);
    l2_t   = !p.layer2_present || l2.c8 == key_cfg;
    l2_pri = p.layer2_over && !l2_t;
    ula_c  = ula_raw;
    tm_c   = tm_raw;
    res    = fallback_cfg;

    if (stencil_cfg && ula_en && tm_en) begin
      fin_t = ula_t || tm_t;
      fin_c = fin_t ? colour_t'('0) : (ula_raw & tm_raw);
    end else begin
      if (ula_t) ula_c = '0;
      if (tm_t) tm_c = '0;
      fin_t = ula_t && tm_t;
      fin_c = (!tm_t && (!tm_below || ula_t)) ? tm_c : ula_c;
    end

    // A border pixel with no tile over it yields to an opaque sprite.
    ula_show = !fin_t && !(ula_rim && tm_t && !spr_t);

    case (prio_cfg)
      PRI_SLU: begin
        if (l2_pri) res = l2.c16;
        else if (!spr_t) res = p.sprite_colour;
        else if (!l2_t) res = l2.c16;
        else if (!fin_t) res = fin_c.c16;
      end
      PRI_LSU: begin
        if (!l2_t) res = l2.c16;
        else if (!spr_t) res = p.sprite_colour;
        else if (!fin_t) res = fin_c.c16;
      end
      PRI_SUL: begin
        if (l2_pri) res = l2.c16;
        else if (!spr_t) res = p.sprite_colour;
        else if (!fin_t) res = fin_c.c16;
        else if (!l2_t) res = l2.c16;
      end
      PRI_LUS: begin
        if (!l2_t) res = l2.c16;
        else if (ula_show) res = fin_c.c16;
        else if (!spr_t) res = p.sprite_colour;
      end
      PRI_USL: begin
        if (l2_pri) res = l2.c16;
        else if (ula_show) res = fin_c.c16;
        else if (!spr_t) res = p.sprite_colour;
        else if (!l2_t) res = l2.c16;
      end
      PRI_ULS: begin
        if (l2_pri) res = l2.c16;
        else if (ula_show) res = fin_c.c16;
        else if (!l2_t) res = l2.c16;
        else if (!spr_t) res = p.sprite_colour;
      end
      default: begin
        // The ULA mix colour ignores the enable bit and reads as black when keyed.
        umix_t = ula_clip || ula_raw.c8 == key_cfg;
        case (mix_cfg)
          MIX_ULA: begin
            mix = umix_t ? colour_t'('0) : ula_c;
            mix_t = umix_t;
            top_t = tm_t || tm_below;
            bot_t = tm_t || !tm_below;
            top_c = tm_c;
            bot_c = tm_c;
          end
          MIX_ULA_TM: begin
            mix = fin_c;
            mix_t = fin_t;
            top_t = 1'b1;
            bot_t = 1'b1;
            top_c = tm_c;
            bot_c = tm_c;
          end
          MIX_TILEMAP: begin
            mix = tm_c;
            mix_t = tm_t;
            top_t = ula_t || !tm_below;
            bot_t = ula_t || tm_below;
            top_c = ula_c;
            bot_c = ula_c;
          end
          default: begin
            mix = '0;
            mix_t = 1'b1;
            top_t = tm_below ? ula_t : tm_t;
            top_c = tm_below ? ula_c : tm_c;
            bot_t = tm_below ? tm_t : ula_t;
            bot_c = tm_below ? tm_c : ula_c;
          end
        endcase
        if (l2_pri) res = blend_colour(l2.c9, mix.c9, mix_t);
        else if (!top_t) res = top_c.c16;
        else if (!spr_t) res = p.sprite_colour;
        else if (!bot_t) res = bot_c.c16;
        else if (!l2_t) res = blend_colour(l2.c9, mix.c9, mix_t);
      end
    endcase
    return res;
  endfunction

  function automatic logic [32:0] rand_colour();
    logic [32:0] c;
    c[31:0] = $urandom;
    c[32] = 1'($urandom_range(0, 1));
    // Hit the key colour often so each layer that uses it is seen transparent.
    if ($urandom_range(0, 3) == 0) c[7:0] = key_cfg;
    return c;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.ula_flags      = 3'($urandom_range(0, 7));
    p.ula_colour     = rand_colour();
    p.tile_flags     = 4'($urandom_range(0, 15));
    p.tile_colour    = rand_colour();
    p.sprite_present = 1'($urandom_range(0, 1));
    p.sprite_colour  = 16'($urandom_range(0, 65535));
    p.layer2_present = 1'($urandom_range(0, 1));
    p.layer2_over    = 1'($urandom_range(0, 1));
    p.layer2_colour  = rand_colour();
    if ($urandom_range(0, 3) != 0) p.ula_flags[0] = 1'b1;
    if ($urandom_range(0, 3) != 0) p.tile_flags[0] = 1'b1;
    return p;
  endfunction

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    case (idx)
      CFG_PRIORITY_ORDER:  prio_cfg = prio_t'(val[2:0]);
      CFG_BLEND_SELECT:    mix_cfg = mix_sel_t'(val[1:0]);
      CFG_STENCIL_ENABLE:  stencil_cfg = val[0];
      CFG_KEY_COLOUR:      key_cfg = val[7:0];
      CFG_FALLBACK_COLOUR: fallback_cfg = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pixels_pending.size() != 0 || colours_expected.size() != 0) @(posedge clk);
  endtask

  // Driver: a beat stays on the bus until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!in_flight) begin
      if (pixels_pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        drv_pixel = pixels_pending[0];
        s_tdata  <= {3'b0, drv_pixel.layer2_colour, drv_pixel.layer2_over,
                     drv_pixel.layer2_present, drv_pixel.sprite_colour,
                     drv_pixel.sprite_present, drv_pixel.tile_colour,
                     drv_pixel.tile_flags, drv_pixel.ula_colour, drv_pixel.ula_flags};
        s_tvalid <= 1'b1;
        in_flight = 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      colours_expected.push_back(mix_pixel(drv_pixel));
      void'(pixels_pending.pop_front());
      in_flight = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (colours_expected.size() == 0) begin
        $display("%0t: pixel colour beat with none expected, actual %h", $time, m_tdata);
        failed = 1'b1;
      end else begin
        if (m_tdata !== colours_expected[0]) begin
          $display("%0t: pixel_colour mismatch, expected %h, actual %h",
                   $time, colours_expected[0], m_tdata);
          failed = 1'b1;
        end
        void'(colours_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("%0t: no beat for %0d cycles", $time, stall_cnt);
      $display("[layer_priority_pixel_mixer_top] ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    pixel_t d;
    send_idle = 19;
    recv_idle = 67;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pixels under the reset register values.
    for (int k = 0; k < 14; k++) begin
      d = rand_pixel();
      d.ula_flags      = '0;
      d.tile_flags     = '0;
      d.sprite_present = 1'b0;
      d.layer2_present = 1'b0;
      d.layer2_over    = 1'b0;
      d.ula_colour[7:0]    = 8'h10;
      d.tile_colour[7:0]   = 8'h20;
      d.layer2_colour[7:0] = 8'h30;
      case (k)
        0: begin
          d.ula_colour = '0;
          d.tile_colour = '0;
          d.sprite_colour = '0;
          d.layer2_colour = '0;
        end
        1: begin
          d.ula_flags = '1;
          d.ula_colour = '1;
          d.tile_flags = '1;
          d.tile_colour = '1;
          d.sprite_present = 1'b1;
          d.sprite_colour = '1;
          d.layer2_present = 1'b1;
          d.layer2_over = 1'b1;
          d.layer2_colour = '1;
        end
        2: d.ula_flags = 3'b001;
        3: begin
          d.ula_flags = 3'b001;
          d.ula_colour[7:0] = key_cfg;
        end
        4: d.ula_flags = 3'b101;
        5: d.tile_flags = 4'b0011;
        6: begin
          d.tile_flags = 4'b1011;
          d.tile_colour[7:0] = key_cfg;
        end
        7: begin
          d.ula_flags = 3'b001;
          d.tile_flags = 4'b0111;
        end
        8: d.sprite_present = 1'b1;
        9: d.layer2_present = 1'b1;
        10: begin
          d.layer2_present = 1'b1;
          d.layer2_over = 1'b1;
          d.sprite_present = 1'b1;
        end
        11: begin
          d.layer2_present = 1'b1;
          d.layer2_colour[7:0] = key_cfg;
        end
        12: begin
          d.ula_flags = 3'b011;
          d.sprite_present = 1'b1;
        end
        default: begin
          d.ula_flags = 3'b001;
          d.tile_flags = 4'b0011;
          d.sprite_present = 1'b1;
          d.layer2_present = 1'b1;
        end
      endcase
      pixels_pending.push_back(d);
    end
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph < 11) begin
        send_idle = 19;
        recv_idle = 67;
      end else if (ph < 22) begin
        send_idle = 67;
        recv_idle = 19;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(CFG_PRIORITY_ORDER, 16'(ph % 8));
      write_reg(CFG_BLEND_SELECT, 16'(ph / 8));
      write_reg(CFG_STENCIL_ENABLE, 16'(((ph / 8) + (ph % 8) / 2) % 2));
      case (ph % 5)
        0: write_reg(CFG_KEY_COLOUR, 16'h0000);
        1: write_reg(CFG_KEY_COLOUR, 16'h00FF);
        2: write_reg(CFG_KEY_COLOUR, 16'(KeyColourReset));
        default: write_reg(CFG_KEY_COLOUR, 16'($urandom_range(0, 255)));
      endcase
      case (ph % 4)
        0: write_reg(CFG_FALLBACK_COLOUR, 16'hFFFF);
        1: write_reg(CFG_FALLBACK_COLOUR, 16'h0000);
        default: write_reg(CFG_FALLBACK_COLOUR, 16'($urandom_range(0, 65535)));
      endcase
      @(negedge clk);
      wr_en <= 1'b0;
      for (int i = 0; i < PhaseItems; i++) pixels_pending.push_back(rand_pixel());
      wait_drained();
    end

    repeat (6) @(posedge clk);
    if (!failed) begin
      $display("[layer_priority_pixel_mixer_top] OK");
    end else begin
      $display("[layer_priority_pixel_mixer_top] ERROR");
    end
    $finish;
  end

endmodule
